// File: hdl/fdbs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the first-duplicate bitmap scan unit.
package fdbs_pkg;

    localparam int VALUE_W   = 16;
    localparam int LENGTH_W  = 11;
    localparam int STATUS_W  = 2;
    localparam int DUP_W     = 10;
    localparam int CMP_W     = 17;
    localparam int EPOCH_W   = 8;
    localparam int M_TDATA_W = 16;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [EPOCH_W-1:0]  epoch_t;

    localparam status_t STATUS_DUP    = 2'd0;
    localparam status_t STATUS_NO_DUP = 2'd1;
    localparam status_t STATUS_RANGE  = 2'd2;

    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = {EPOCH_W{1'b1}};
    localparam epoch_t EPOCH_CLEAR = '0;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;

endpackage

// File: hdl/fdbs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module fdbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/first_duplicate_bitmap_scan_unit.sv
`timescale 1ns / 1ps
// Top level: first-duplicate scan over lists, tagged seen bitmap in a RAM.
// Throughput: one transaction per cycle outside the bitmap clear; a list end waits while the previous result is held.
// Result path: an accepted value is registered in stage s1, then the list's result in the output register.
// Bitmap entries carry a list tag; a zeroing sweep over all MAX_LEN entries runs after reset and
// after every 255th list (s_axis_tready low from its last value until the sweep ends).
// Reset: synchronous, active-low aresetn; list_length returns to 1024.
module first_duplicate_bitmap_scan_unit #(
    parameter int MAX_LEN = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [fdbs_pkg::LENGTH_W-1:0]    cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fdbs_pkg::VALUE_W-1:0]     s_axis_tdata,   // [15:0] value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fdbs_pkg::M_TDATA_W-1:0]   m_axis_tdata    // [1:0] status, [11:2] dup_value
);
    import fdbs_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam logic [CMP_W-1:0]  MAX_CMP   = CMP_W'(MAX_LEN);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_LEN - 1);

    logic [LENGTH_W-1:0] len_reg;
    logic [LEN_W-1:0]    count_reg;
    logic                s1_valid_reg, s1_inrange_reg, s1_last_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [DUP_W-1:0]    s1_dup_reg;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic                dup_found_reg, range_err_reg;
    logic [DUP_W-1:0]    dup_held_reg;
    epoch_t              epoch_reg;
    logic                clr_active_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [DUP_W-1:0]    m_dup_reg;

    logic [CMP_W-1:0]  len_cmp, eff_len, raw_cmp, count_inc;
    logic              in_range, in_last, accept, en, seen, wrap_hold;
    logic [ADDR_W-1:0] in_addr;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    epoch_t            ram_wr_data, ram_rd_data;
    logic              dup_found_next, range_err_next;
    logic [DUP_W-1:0]  dup_held_next;
    status_t           status_next;

    always_comb begin
        len_cmp = CMP_W'(len_reg);
        if (len_cmp == '0) begin
            eff_len = CMP_W'(1);
        end else if (len_cmp > MAX_CMP) begin
            eff_len = MAX_CMP;
        end else begin
            eff_len = len_cmp;
        end
    end

    assign raw_cmp   = {1'b0, s_axis_tdata};
    assign in_range  = !s_axis_tdata[VALUE_W-1] && (raw_cmp < eff_len);
    assign in_addr   = raw_cmp[ADDR_W-1:0];
    assign count_inc = CMP_W'(count_reg) + CMP_W'(1);
    assign in_last   = count_inc >= eff_len;

    assign en        = !(s1_valid_reg && s1_last_reg && m_valid_reg && !m_axis_tready);
    assign wrap_hold = s1_valid_reg && s1_last_reg && (epoch_reg == EPOCH_LAST);
    assign s_axis_tready = en && !clr_active_reg && !wrap_hold;
    assign accept    = s_axis_tvalid && s_axis_tready;

    assign seen = (ram_rd_data == epoch_reg) ||
                  (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg));

    always_comb begin
        if (clr_active_reg) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = EPOCH_CLEAR;
        end else begin
            ram_wr_en   = s1_valid_reg && en && s1_inrange_reg && !seen;
            ram_wr_addr = s1_addr_reg;
            ram_wr_data = epoch_reg;
        end
    end

    fdbs_ram #(
        .WIDTH(EPOCH_W),
        .DEPTH(MAX_LEN)
    ) u_seen_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (accept),
        .rd_addr(in_addr),
        .rd_data(ram_rd_data)
    );

    always_comb begin
        dup_found_next = dup_found_reg || (s1_inrange_reg && seen);
        dup_held_next  = (!dup_found_reg && s1_inrange_reg && seen) ? s1_dup_reg
                                                                    : dup_held_reg;
        range_err_next = range_err_reg || !s1_inrange_reg;
        if (range_err_next) begin
            status_next = STATUS_RANGE;
        end else if (dup_found_next) begin
            status_next = STATUS_DUP;
        end else begin
            status_next = STATUS_NO_DUP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= LENGTH_RESET;
            count_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            dup_found_reg  <= 1'b0;
            dup_held_reg   <= '0;
            range_err_reg  <= 1'b0;
            epoch_reg      <= EPOCH_FIRST;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end

            if (clr_active_reg) begin
                if (clr_addr_reg == ADDR_LAST) begin
                    clr_active_reg <= 1'b0;
                    clr_addr_reg   <= '0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
            end

            if (accept) begin
                count_reg <= in_last ? '0 : LEN_W'(count_inc);
            end

            if (m_valid_reg && m_axis_tready && !(en && s1_valid_reg && s1_last_reg)) begin
                m_valid_reg <= 1'b0;
            end

            if (en) begin
                s1_valid_reg  <= accept;
                fwd_valid_reg <= s1_valid_reg && s1_inrange_reg && !s1_last_reg;
                if (s1_valid_reg) begin
                    if (s1_last_reg) begin
                        m_valid_reg   <= 1'b1;
                        dup_found_reg <= 1'b0;
                        dup_held_reg  <= '0;
                        range_err_reg <= 1'b0;
                        if (epoch_reg == EPOCH_LAST) begin
                            epoch_reg      <= EPOCH_FIRST;
                            clr_active_reg <= 1'b1;
                            clr_addr_reg   <= '0;
                        end else begin
                            epoch_reg <= epoch_reg + epoch_t'(1);
                        end
                    end else begin
                        dup_found_reg <= dup_found_next;
                        dup_held_reg  <= dup_held_next;
                        range_err_reg <= range_err_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg    <= in_addr;
            s1_inrange_reg <= in_range;
            s1_last_reg    <= in_last;
            s1_dup_reg     <= s_axis_tdata[DUP_W-1:0];
        end
        if (en) begin
            fwd_addr_reg <= s1_addr_reg;
        end
        if (en && s1_valid_reg && s1_last_reg) begin
            m_status_reg <= status_next;
            m_dup_reg    <= (status_next == STATUS_DUP) ? dup_held_next : '0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_dup_reg, m_status_reg});

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !accept)
        else $error("transaction accepted during bitmap clear");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready && s1_valid_reg && s1_last_reg) |-> !en)
        else $error("pending result would be overwritten");

    a_epoch_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != EPOCH_CLEAR)
        else $error("list tag collides with cleared tag");

    a_dup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STATUS_DUP)) |-> (m_dup_reg == '0))
        else $error("dup_value nonzero without duplicate status");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_status_reg == STATUS_DUP || m_status_reg == STATUS_NO_DUP ||
                         m_status_reg == STATUS_RANGE))
        else $error("illegal status code");
`endif

endmodule

// File: sim/first_duplicate_bitmap_scan_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-duplicate bitmap scan unit, driven with directed and random lists.
module first_duplicate_bitmap_scan_unit_tb;
    import fdbs_pkg::*;

    localparam int MAX_LEN = 1024;

    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        status_t           status;
        logic [DUP_W-1:0]  dup_value;
    } scan_verdict_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [LENGTH_W-1:0]  cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    value_t               s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // scan state mirrored in the testbench
    bit                  seen_bits [MAX_LEN];
    int unsigned         values_in_list = 0;
    bit                  dup_seen = 1'b0;
    logic [DUP_W-1:0]    first_dup = '0;
    bit                  out_of_range = 1'b0;
    logic [LENGTH_W-1:0] list_length = LENGTH_RESET;

    scan_verdict_t verdicts_due[$];
    int unsigned   mismatches = 0;
    int unsigned   send_gap_pct = 0;
    int unsigned   accept_stall_pct = 0;
    int unsigned   hold_off_cycles = 0;

    first_duplicate_bitmap_scan_unit #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // Update the mirrored scan with one accepted value; queue the verdict at list end.
    function automatic void scan_value(input value_t v);
        int unsigned   len;
        scan_verdict_t verdict;
        len = (list_length == 0) ? 1 : ((list_length > MAX_LEN) ? MAX_LEN : list_length);
        if (v[VALUE_W-1] || v >= len) begin
            out_of_range = 1'b1;
        end else if (seen_bits[v[DUP_W-1:0]]) begin
            if (!dup_seen) begin
                dup_seen  = 1'b1;
                first_dup = v[DUP_W-1:0];
            end
        end else begin
            seen_bits[v[DUP_W-1:0]] = 1'b1;
        end
        values_in_list++;
        if (values_in_list >= len) begin
            verdict.dup_value = '0;
            if (out_of_range) begin
                verdict.status = STATUS_RANGE;
            end else if (dup_seen) begin
                verdict.status    = STATUS_DUP;
                verdict.dup_value = first_dup;
            end else begin
                verdict.status = STATUS_NO_DUP;
            end
            verdicts_due.push_back(verdict);
            foreach (seen_bits[i]) seen_bits[i] = 1'b0;
            values_in_list = 0;
            dup_seen       = 1'b0;
            first_dup      = '0;
            out_of_range   = 1'b0;
        end
    endfunction

    function automatic void make_permutation(input int unsigned len, ref value_t vals[$]);
        int unsigned j;
        value_t      tmp;
        vals.delete();
        for (int unsigned i = 0; i < len; i++) vals.push_back(value_t'(i));
        for (int unsigned i = len - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
    endfunction

    // Result side: random or held-off tready, every transaction checked in order.
    always @(posedge aclk) begin
        scan_verdict_t got;
        scan_verdict_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_off_cycles != 0) begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= accept_stall_pct);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tdata[STATUS_W-1:0];
                got.dup_value = m_axis_tdata[STATUS_W+DUP_W-1:STATUS_W];
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d dup %0d",
                                 got.status, got.dup_value);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.status != want.status || got.dup_value != want.dup_value) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status exp %0d got %0d, dup exp %0d got %0d",
                                     want.status, got.status, want.dup_value, got.dup_value);
                    end
                end
            end
        end
    end

    task automatic send_value(input value_t v);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        scan_value(v);
    endtask

    task automatic send_list(input value_t vals[$]);
        foreach (vals[i]) send_value(vals[i]);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(input logic [LENGTH_W-1:0] n);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        list_length = n;
    endtask

    task automatic test_reset_length_permutation();
        value_t      vals[$];
        int unsigned p;
        make_permutation(MAX_LEN, vals);
        p       = $urandom_range(MAX_LEN - 24, MAX_LEN - 1);
        vals[p] = vals[$urandom_range(0, p - 1)];
        // list opens at the reset length; a saturated length then carries the count on
        for (int i = 0; i < MAX_LEN - 24; i++) send_value(vals[i]);
        write_length(11'h7FF);
        for (int i = MAX_LEN - 24; i < MAX_LEN; i++) send_value(vals[i]);
    endtask

    task automatic test_corner_values();
        write_length(11'd0);
        send_list('{16'd0, 16'd1, 16'hFFFF});
        write_length(11'd1);
        send_list('{16'd0, 16'h7FFF});
        write_length(11'd4);
        send_list('{16'd3, 16'd3, 16'd3, 16'd0});
        send_list('{16'h8000, 16'd1, 16'd1, 16'd2});
        send_list('{16'd1, 16'd2, 16'd2, 16'd1});
        send_list('{16'd3, 16'd2, 16'd1, 16'd4});
    endtask

    task automatic test_mid_list_length_change();
        write_length(11'd6);
        send_list('{16'd0, 16'd1, 16'd1, 16'd5});
        // count already past the new length: next value closes the list
        write_length(11'd2);
        send_value(16'd0);
        send_value(16'd1);
        write_length(11'd5);
        send_list('{16'd2, 16'd3, 16'd4, 16'd1});
    endtask

    task automatic test_saturated_length();
        // top value stays in range, then a short length closes the list
        write_length(11'h7FF);
        send_value(value_t'(MAX_LEN - 1));
        send_value(value_t'(MAX_LEN - 1));
        write_length(11'd1);
        send_value(16'd0);
        // first value past the saturated bound is out of range
        write_length(11'h7FF);
        send_value(value_t'(MAX_LEN));
        write_length(11'd1);
        send_value(16'd0);
    endtask

    task automatic test_output_backpressure();
        write_length(11'd1);
        hold_off_cycles = 300;
        repeat (24) send_value(value_t'($urandom_range(1)));
        wait_idle();
    endtask

    task automatic test_random_lists();
        int unsigned gap_by_phase   [4] = '{0, 62, 0, 15};
        int unsigned stall_by_phase [4] = '{0, 0, 62, 15};
        value_t      vals[$];
        int unsigned len;
        int unsigned sent;
        int unsigned pick;
        int unsigned p;
        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct     = gap_by_phase[ph];
            accept_stall_pct = stall_by_phase[ph];
            for (int part = 0; part < 2; part++) begin
                if (ph == 0 && part == 0)
                    len = 1;
                else if (part == 1)
                    len = $urandom_range(9, 20);
                else
                    len = $urandom_range(2, 8);
                write_length(LENGTH_W'(len));
                sent = 0;
                while (sent < 10) begin
                    pick = $urandom_range(99);
                    vals.delete();
                    if (pick >= 35 && pick < 75) begin
                        for (int unsigned i = 0; i < len; i++)
                            vals.push_back(value_t'($urandom_range(len - 1)));
                    end else if (pick >= 95) begin
                        for (int unsigned i = 0; i < len; i++)
                            vals.push_back(value_t'($urandom()));
                    end else begin
                        make_permutation(len, vals);
                        if (pick >= 75 && pick < 85 && len > 1) begin
                            p       = $urandom_range(1, len - 1);
                            vals[p] = vals[$urandom_range(0, p - 1)];
                        end else if (pick >= 85) begin
                            p = $urandom_range(0, len - 1);
                            case ($urandom_range(4))
                                0:       vals[p] = value_t'(len);
                                1:       vals[p] = 16'hFFFF;
                                2:       vals[p] = 16'h8000;
                                3:       vals[p] = 16'h7FFF;
                                default: vals[p] = value_t'($urandom());
                            endcase
                        end
                    end
                    send_list(vals);
                    sent += len;
                end
            end
        end
        send_gap_pct     = 0;
        accept_stall_pct = 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_length_permutation();
        test_corner_values();
        test_mid_list_length_change();
        test_saturated_length();
        test_output_backpressure();
        test_random_lists();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("first_duplicate_bitmap_scan_unit verification clean");
        end else begin
            $display("first_duplicate_bitmap_scan_unit verification failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("first_duplicate_bitmap_scan_unit verification failed");
        $finish;
    end

endmodule

// File: first_duplicate_bitmap_scan_unit.f
hdl/fdbs_pkg.sv
hdl/fdbs_ram.sv
hdl/first_duplicate_bitmap_scan_unit.sv
sim/first_duplicate_bitmap_scan_unit_tb.sv
